// File: rtl/core/apsp_pkg.sv
// shared constants, item types and codes for the all-pairs shortest path block
`timescale 1ns / 1ps

package apsp_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int WEIGHT_BITS  = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int CFG_W        = 6;

  localparam logic [WEIGHT_BITS-1:0] NO_EDGE    = '1;
  localparam logic [WEIGHT_BITS-1:0] MAX_FINITE = NO_EDGE - WEIGHT_BITS'(1);

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDRSP,
    ST_IK_RD,
    ST_IK_CHK,
    ST_J_RD,
    ST_J_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic [WEIGHT_BITS-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] distance;
    logic                   overflow;
    logic                   index_error;
  } out_item_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [WEIGHT_BITS-1:0] wdata;
    logic [ADDR_W-1:0]      raddr_a;
    logic [ADDR_W-1:0]      raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic                   upd;
    logic [WEIGHT_BITS-1:0] value;
    logic                   ovf;
  } relax_t;

endpackage

// File: rtl/core/all_pairs_shortest_paths_top.sv
// top level of the all-pairs shortest path block
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   in_item_i   (in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o  (out_item_t)
//   cfg      input      cfg_we_i                  cfg_data_i  (n_used)
//
// write item: result registered on acceptance; read item: through the registered memory read
// solve item: for n vertices in use, each k and i reads d(i,k) and skips the row if it is
//   no edge, else each j is read then relaxed through the single memory and relaxation unit
// reset clears control state and the overflow flag; the matrix is not cleared
// an item is taken only while idle and the result register is free or draining
`timescale 1ns / 1ps

module all_pairs_shortest_paths_top
  import apsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  mem_req_t               mem_req;
  logic [WEIGHT_BITS-1:0] rdata_a;
  logic [WEIGHT_BITS-1:0] rdata_b;
  logic [WEIGHT_BITS-1:0] ik;
  relax_t                 relax;

  apsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .rdata_a_i   (rdata_a),
    .ik_o        (ik),
    .relax_i     (relax)
  );

  apsp_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  apsp_relax u_relax (
    .ik_i  (ik),
    .kj_i  (rdata_a),
    .ij_i  (rdata_b),
    .res_o (relax)
  );

endmodule

// File: rtl/core/apsp_mem.sv
// distance matrix memory, one write port and two registered read ports
`timescale 1ns / 1ps

module apsp_mem
  import apsp_pkg::*;
(
  input  logic                   clk_i,
  input  mem_req_t               req_i,
  output logic [WEIGHT_BITS-1:0] rdata_a_o,
  output logic [WEIGHT_BITS-1:0] rdata_b_o
);

  logic [WEIGHT_BITS-1:0] mem_q [MAX_VERTICES*MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] rdata_a_q;
  logic [WEIGHT_BITS-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q <= mem_q[req_i.raddr_a];
    rdata_b_q <= mem_q[req_i.raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/core/apsp_relax.sv
// shared relaxation unit: saturating add and compare against the current distance
`timescale 1ns / 1ps

module apsp_relax
  import apsp_pkg::*;
(
  input  logic [WEIGHT_BITS-1:0] ik_i,
  input  logic [WEIGHT_BITS-1:0] kj_i,
  input  logic [WEIGHT_BITS-1:0] ij_i,
  output relax_t                 res_o
);

  logic [WEIGHT_BITS:0]   sum;
  logic                   both_finite;
  logic                   sat;
  logic [WEIGHT_BITS-1:0] val;

  assign both_finite = (ik_i != NO_EDGE) && (kj_i != NO_EDGE);
  assign sum         = {1'b0, ik_i} + {1'b0, kj_i};
  assign sat         = sum >= {1'b0, NO_EDGE};
  assign val         = sat ? MAX_FINITE : sum[WEIGHT_BITS-1:0];

  assign res_o.value = val;
  assign res_o.ovf   = both_finite && sat;
  assign res_o.upd   = both_finite && (val < ij_i);

endmodule

// File: rtl/core/apsp_ctrl.sv
// sequencer: item decode, k-i-j relaxation loop, result register and flags
`timescale 1ns / 1ps

module apsp_ctrl
  import apsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  output mem_req_t               mem_req_o,
  input  logic [WEIGHT_BITS-1:0] rdata_a_i,
  output logic [WEIGHT_BITS-1:0] ik_o,
  input  relax_t                 relax_i
);

  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       n_used_q;
  logic [IDX_W-1:0]       k_q, k_d, i_q, i_d, j_q, j_d;
  logic [WEIGHT_BITS-1:0] ik_q, ik_d;
  logic                   ovf_q, ovf_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic [CNT_W-1:0] n_eff;
  logic             ready;
  logic             accept;
  logic             idx_ok;
  logic             last_k, last_i, last_j;

  assign n_eff  = (CNT_W'(n_used_q) > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                              : CNT_W'(n_used_q);
  assign ready  = (state_q == ST_IDLE) && (!out_valid_q || !out_stall_i);
  assign accept = in_valid_i && ready;
  assign idx_ok = (CNT_W'(in_item_i.row) < n_eff) && (CNT_W'(in_item_i.col) < n_eff);
  assign last_k = (CNT_W'(k_q) + CNT_W'(1)) == n_eff;
  assign last_i = (CNT_W'(i_q) + CNT_W'(1)) == n_eff;
  assign last_j = (CNT_W'(j_q) + CNT_W'(1)) == n_eff;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority case (in_item_i.req_type)
            REQ_READ:  state_d = idx_ok ? ST_RDRSP : ST_IDLE;
            REQ_SOLVE: state_d = (n_eff != '0) ? ST_IK_RD : ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_RDRSP: state_d = ST_IDLE;
      ST_IK_RD: state_d = ST_IK_CHK;
      ST_IK_CHK: begin
        if (rdata_a_i != NO_EDGE) begin
          state_d = ST_J_RD;
        end else if (last_i && last_k) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_IK_RD;
        end
      end
      ST_J_RD: state_d = ST_J_UPD;
      ST_J_UPD: begin
        if (!last_j) begin
          state_d = ST_J_RD;
        end else if (last_i && last_k) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_IK_RD;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs, counters and memory control
  always_comb begin
    in_stall_o        = !ready;
    mem_req_o.we      = 1'b0;
    mem_req_o.waddr   = {in_item_i.row, in_item_i.col};
    mem_req_o.wdata   = in_item_i.weight;
    mem_req_o.raddr_a = {in_item_i.row, in_item_i.col};
    mem_req_o.raddr_b = {i_q, j_q};
    k_d               = k_q;
    i_d               = i_q;
    j_d               = j_q;
    ik_d              = ik_q;
    ovf_d             = ovf_q;
    out_valid_d       = out_valid_q && out_stall_i;
    out_item_d        = out_item_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          k_d = '0;
          i_d = '0;
          j_d = '0;
          out_item_d.distance    = '0;
          out_item_d.overflow    = ovf_q;
          out_item_d.index_error = 1'b0;
          priority case (in_item_i.req_type)
            REQ_WRITE: begin
              mem_req_o.we           = idx_ok;
              out_item_d.index_error = !idx_ok;
              out_valid_d            = 1'b1;
            end
            REQ_READ: begin
              out_item_d.index_error = !idx_ok;
              out_valid_d            = !idx_ok;
            end
            REQ_SOLVE: begin
              out_valid_d = (n_eff == '0);
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_RDRSP: begin
        out_item_d.distance    = rdata_a_i;
        out_item_d.overflow    = ovf_q;
        out_item_d.index_error = 1'b0;
        out_valid_d            = 1'b1;
      end
      ST_IK_RD: begin
        mem_req_o.raddr_a = {i_q, k_q};
      end
      ST_IK_CHK: begin
        ik_d = rdata_a_i;
        j_d  = '0;
        if (rdata_a_i == NO_EDGE) begin
          if (last_i) begin
            i_d = '0;
            k_d = k_q + IDX_W'(1);
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end
      end
      ST_J_RD: begin
        mem_req_o.raddr_a = {k_q, j_q};
        mem_req_o.raddr_b = {i_q, j_q};
      end
      ST_J_UPD: begin
        mem_req_o.we    = relax_i.upd;
        mem_req_o.waddr = {i_q, j_q};
        mem_req_o.wdata = relax_i.value;
        ovf_d           = ovf_q || relax_i.ovf;
        if (!last_j) begin
          j_d = j_q + IDX_W'(1);
        end else begin
          j_d = '0;
          if (last_i) begin
            i_d = '0;
            k_d = k_q + IDX_W'(1);
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end
      end
      ST_DONE: begin
        out_item_d.distance    = '0;
        out_item_d.overflow    = ovf_q;
        out_item_d.index_error = 1'b0;
        out_valid_d            = 1'b1;
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_used_q    <= CFG_W'(MAX_VERTICES);
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        n_used_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ik_q       <= ik_d;
    out_item_q <= out_item_d;
  end

  assign ik_o        = ik_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result pending while a multi-cycle item is in progress");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_idx_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.index_error) |-> (out_item_q.distance == '0))
    else $error("index error with nonzero distance");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_J_UPD) |->
      ((CNT_W'(k_q) < n_eff) && (CNT_W'(i_q) < n_eff) && (CNT_W'(j_q) < n_eff)))
    else $error("loop counter beyond vertex count");
`endif

endmodule
